FILE: sv/cda_pkg.sv
package cda_pkg;

	// calendar limits
	localparam logic [13:0] MAX_YEAR      = 14'd9999;
	localparam logic [3:0]  MONTH_FIRST   = 4'd1;
	localparam logic [3:0]  MONTH_FEB     = 4'd2;
	localparam logic [3:0]  MONTH_LAST    = 4'd12;
	localparam logic [4:0]  DAYS_DEC      = 5'd31;
	localparam logic [12:0] DAYS_PER_YEAR = 13'd365;

	// floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT, exact for x below 43690
	localparam logic [12:0] RECIP_100   = 13'd5243;
	localparam int          RECIP_SHIFT = 19;

	// command modes
	localparam logic [1:0] MODE_SET = 2'd0;
	localparam logic [1:0] MODE_ADD = 2'd1;
	localparam logic [1:0] MODE_CMP = 2'd2;
	localparam logic [1:0] MODE_BAD = 2'd3;

	typedef logic [3:0] op_t;
	typedef logic [4:0] pc_t;
	typedef logic [1:0] jmp_t;

	// datapath operations
	localparam op_t OP_NOP    = 4'd0;
	localparam op_t OP_LDO    = 4'd1;  // operand <- given date
	localparam op_t OP_LDH    = 4'd2;  // operand <- held date
	localparam op_t OP_QY     = 4'd3;  // year / 100
	localparam op_t OP_LEAP   = 4'd4;  // leap flag of operand year
	localparam op_t OP_SET    = 4'd5;
	localparam op_t OP_LDW    = 4'd6;  // load month walker
	localparam op_t OP_STEP   = 4'd7;  // one month per cycle
	localparam op_t OP_COMMIT = 4'd8;
	localparam op_t OP_MA     = 4'd9;  // year * 365
	localparam op_t OP_MB     = 4'd10; // (year + 99) / 100
	localparam op_t OP_MC     = 4'd11; // (year + 399) / 100
	localparam op_t OP_SUM    = 4'd12; // day serial
	localparam op_t OP_DIFF   = 4'd13;
	localparam op_t OP_BAD    = 4'd14;

	// sequencing
	localparam jmp_t J_NEXT = 2'd0;
	localparam jmp_t J_WAIT = 2'd1; // back to target until the walker finishes
	localparam jmp_t J_END  = 2'd2; // hand the result over, then idle

	typedef struct packed {
		op_t  op;
		jmp_t jmp;
		pc_t  tgt;
	} ucode_t;

	typedef struct packed {
		logic cap;
		op_t  op;
	} dp_ctl_t;

	typedef struct packed {
		logic fin;
	} dp_sts_t;

	localparam pc_t E_SET = 5'd0;
	localparam pc_t E_ADD = 5'd5;
	localparam pc_t E_CMP = 5'd11;
	localparam pc_t E_BAD = 5'd27;

	function automatic ucode_t ucode_rom(input pc_t a);
		case (a)
			5'd0:    return '{OP_LDO,    J_NEXT, 5'd0};
			5'd1:    return '{OP_QY,     J_NEXT, 5'd0};
			5'd2:    return '{OP_LEAP,   J_NEXT, 5'd0};
			5'd3:    return '{OP_SET,    J_NEXT, 5'd0};
			5'd4:    return '{OP_NOP,    J_END,  5'd0};
			5'd5:    return '{OP_LDH,    J_NEXT, 5'd0};
			5'd6:    return '{OP_QY,     J_NEXT, 5'd0};
			5'd7:    return '{OP_LDW,    J_NEXT, 5'd0};
			5'd8:    return '{OP_STEP,   J_WAIT, 5'd8};
			5'd9:    return '{OP_COMMIT, J_NEXT, 5'd0};
			5'd10:   return '{OP_NOP,    J_END,  5'd0};
			5'd11:   return '{OP_LDH,    J_NEXT, 5'd0};
			5'd12:   return '{OP_QY,     J_NEXT, 5'd0};
			5'd13:   return '{OP_LEAP,   J_NEXT, 5'd0};
			5'd14:   return '{OP_MA,     J_NEXT, 5'd0};
			5'd15:   return '{OP_MB,     J_NEXT, 5'd0};
			5'd16:   return '{OP_MC,     J_NEXT, 5'd0};
			5'd17:   return '{OP_SUM,    J_NEXT, 5'd0};
			5'd18:   return '{OP_LDO,    J_NEXT, 5'd0};
			5'd19:   return '{OP_QY,     J_NEXT, 5'd0};
			5'd20:   return '{OP_LEAP,   J_NEXT, 5'd0};
			5'd21:   return '{OP_MA,     J_NEXT, 5'd0};
			5'd22:   return '{OP_MB,     J_NEXT, 5'd0};
			5'd23:   return '{OP_MC,     J_NEXT, 5'd0};
			5'd24:   return '{OP_SUM,    J_NEXT, 5'd0};
			5'd25:   return '{OP_DIFF,   J_NEXT, 5'd0};
			5'd26:   return '{OP_NOP,    J_END,  5'd0};
			5'd27:   return '{OP_BAD,    J_NEXT, 5'd0};
			5'd28:   return '{OP_NOP,    J_END,  5'd0};
			default: return '{OP_NOP,    J_END,  5'd0};
		endcase
	endfunction

	function automatic logic [4:0] dim_f(input logic [3:0] m, input logic lp);
		case (m) inside
			4'd2:                                       return lp ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:                    return 5'd30;
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
			default:                                    return 5'd0;
		endcase
	endfunction

	// days in the year before the first of the month, common year
	function automatic logic [8:0] cum_f(input logic [3:0] m);
		case (m)
			4'd1:    return 9'd0;
			4'd2:    return 9'd31;
			4'd3:    return 9'd59;
			4'd4:    return 9'd90;
			4'd5:    return 9'd120;
			4'd6:    return 9'd151;
			4'd7:    return 9'd181;
			4'd8:    return 9'd212;
			4'd9:    return 9'd243;
			4'd10:   return 9'd273;
			4'd11:   return 9'd304;
			4'd12:   return 9'd334;
			default: return 9'd0;
		endcase
	endfunction

	function automatic logic date_ok(input logic [13:0] y, input logic [3:0] m,
			input logic [4:0] d, input logic lp);
		return (y <= MAX_YEAR) && (m >= MONTH_FIRST) && (m <= MONTH_LAST) &&
			(d != 5'd0) && (d <= dim_f(m, lp));
	endfunction

endpackage

FILE: sv/calendar_date_arithmetic_core.sv
// channel | dir | tdata (low bit up)                                      | tuser
// s_axis  | in  | mode 2, day_count 17 s, other_year 14, other_month 4,    | -
//         |     | other_day 5, zero pad 6                                  |
// m_axis  | out | cur_year 14, cur_month 4, cur_day 5, day_difference 23 s,| error
//         |     | is_before 1, is_equal 1                                  |
//
// add runs the month walker, one month per step, so it takes longer for larger day counts
// reset loads the date 0-01-01; no clearing pass
// a new command is taken once the previous one has left the sequencer, even
// while its result still waits in the output register
module calendar_date_arithmetic_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // mode, day_count, other_year, other_month, other_day
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // cur_year, cur_month, cur_day, day_difference,
	                                   // is_before, is_equal
	output logic        m_axis_tuser   // error
);
	import cda_pkg::*;

	// sequencer state
	logic   busy_q;
	pc_t    pc_q;
	ucode_t uw;
	pc_t    entry;

	logic   s_xfer;
	logic   out_free;
	logic   res_load;

	dp_ctl_t ctl;
	dp_sts_t sts;

	// datapath result fields
	logic [13:0]        cur_year;
	logic [3:0]         cur_month;
	logic [4:0]         cur_day;
	logic signed [22:0] day_difference;
	logic               is_before;
	logic               is_equal;
	logic               error;

	logic m_tvalid_q;

	assign s_axis_tready = !busy_q;
	assign s_xfer        = s_axis_tvalid && !busy_q;
	assign out_free      = !m_tvalid_q || m_axis_tready;

	// microcode fetch
	assign uw = ucode_rom(pc_q);

	// end step with a free output register hands the result over
	assign res_load = busy_q && (uw.jmp == J_END) && out_free;

	// program entry by mode
	always_comb begin
		unique case (s_axis_tdata[1:0])
			MODE_SET: entry = E_SET;
			MODE_ADD: entry = E_ADD;
			MODE_CMP: entry = E_CMP;
			MODE_BAD: entry = E_BAD;
			default:  entry = E_BAD;
		endcase
	end

	assign ctl.cap = s_xfer;
	assign ctl.op  = busy_q ? uw.op : OP_NOP;

	cda_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.day_count      ($signed(s_axis_tdata[18:2])),
		.other_year     (s_axis_tdata[32:19]),
		.other_month    (s_axis_tdata[36:33]),
		.other_day      (s_axis_tdata[41:37]),
		.sts            (sts),
		.cur_year       (cur_year),
		.cur_month      (cur_month),
		.cur_day        (cur_day),
		.day_difference (day_difference),
		.is_before      (is_before),
		.is_equal       (is_equal),
		.error          (error)
	);

	// step counter and jumps; the end step waits for a free output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			pc_q       <= E_SET;
			m_tvalid_q <= 1'b0;
		end else begin
			if (res_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (s_xfer) begin
				busy_q <= 1'b1;
				pc_q   <= entry;
			end else if (busy_q) begin
				case (uw.jmp)
					J_NEXT: pc_q <= pc_q + 5'd1;
					J_WAIT: pc_q <= sts.fin ? pc_q + 5'd1 : uw.tgt;
					J_END: begin
						if (out_free) begin
							busy_q <= 1'b0;
						end
					end
					default: busy_q <= 1'b0;
				endcase
			end
		end
	end

	// output register, loaded when the result transfer slot is free
	always_ff @(posedge clk) begin
		if (res_load) begin
			m_axis_tdata <= {is_equal, is_before, day_difference, cur_day, cur_month, cur_year};
			m_axis_tuser <= error;
		end
	end

	assign m_axis_tvalid = m_tvalid_q;

endmodule

FILE: sv/cda_dpath.sv
module cda_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  cda_pkg::dp_ctl_t  ctl,
	input  logic signed [16:0] day_count,
	input  logic [13:0]       other_year,
	input  logic [3:0]        other_month,
	input  logic [4:0]        other_day,
	output cda_pkg::dp_sts_t  sts,
	output logic [13:0]       cur_year,
	output logic [3:0]        cur_month,
	output logic [4:0]        cur_day,
	output logic signed [22:0] day_difference,
	output logic              is_before,
	output logic              is_equal,
	output logic              error
);
	import cda_pkg::*;

	// captured command
	logic signed [16:0] count_q;
	logic [13:0]        gy_q;
	logic [3:0]         gm_q;
	logic [4:0]         gd_q;

	// held date
	logic [13:0] hy_q;
	logic [3:0]  hm_q;
	logic [4:0]  hd_q;

	// operand date and its derived terms
	logic [13:0] oy_q;
	logic [3:0]  om_q;
	logic [4:0]  od_q;
	logic [7:0]  qy_q;
	logic        leap_q;
	logic [22:0] mul_q;
	logic [7:0]  q1_q;
	logic [7:0]  q2_q;
	logic [22:0] ser_q;
	logic [22:0] ser0_q;

	// month walker
	logic [13:0]        wy_q;
	logic [3:0]         wm_q;
	logic [4:0]         wd_q;
	logic [6:0]         w100_q;
	logic [1:0]         wc4_q;
	logic signed [17:0] rem_q;

	logic signed [22:0] diff_q;
	logic               eq_q;
	logic               err_q;

	// shared multiplier
	logic [14:0] mx;
	logic [12:0] mk;
	logic [27:0] prod;

	always_comb begin
		case (ctl.op)
			OP_MA: begin
				mx = {1'b0, oy_q};
				mk = DAYS_PER_YEAR;
			end
			OP_MB: begin
				mx = {1'b0, oy_q} + 15'd99;
				mk = RECIP_100;
			end
			OP_MC: begin
				mx = {1'b0, oy_q} + 15'd399;
				mk = RECIP_100;
			end
			default: begin
				mx = {1'b0, oy_q};
				mk = RECIP_100;
			end
		endcase
	end

	assign prod = 28'(mx) * 28'(mk);

	// leap test of the operand year from year / 100
	logic [14:0] qy100;
	logic [14:0] oy_r100;
	logic        leap_n;

	assign qy100   = 15'(qy_q) * 15'd100;
	assign oy_r100 = {1'b0, oy_q} - qy100;
	assign leap_n  = (oy_q[1:0] == 2'd0) && ((oy_r100 != 15'd0) || (qy_q[1:0] == 2'd0));

	// day serial of the operand
	logic [14:0] y3;
	logic        ladj;
	logic [22:0] ser_n;

	assign y3    = {1'b0, oy_q} + 15'd3;
	assign ladj  = leap_q && (om_q > MONTH_FEB);
	assign ser_n = mul_q + 23'(y3[14:2]) - 23'(q1_q) + 23'(q2_q[7:2])
		+ 23'(cum_f(om_q)) + 23'(ladj) + 23'(od_q);

	logic signed [22:0] diff_n;
	logic               cmp_ok;
	logic               set_ok;

	assign diff_n = $signed(ser0_q - ser_q);
	assign cmp_ok = date_ok(oy_q, om_q, od_q, leap_q);
	assign set_ok = cmp_ok && (oy_q != 14'd0);

	// walker step
	logic               leap_w;
	logic [4:0]         dim_w;
	logic [3:0]         pm;
	logic [4:0]         dim_p;
	logic signed [18:0] t_fwd;
	logic signed [18:0] u_bwd;
	logic               fwd;
	logic               fits;
	logic               ovf;

	assign leap_w = (wy_q[1:0] == 2'd0) && ((w100_q != 7'd0) || (wc4_q == 2'd0));
	assign dim_w  = dim_f(wm_q, leap_w);
	assign pm     = (wm_q == MONTH_FIRST) ? MONTH_LAST : wm_q - 4'd1;
	assign dim_p  = (wm_q == MONTH_FIRST) ? DAYS_DEC : dim_f(pm, leap_w);
	assign t_fwd  = 19'(rem_q) - $signed({14'd0, dim_w}) + $signed({14'd0, wd_q}) - 19'sd1;
	assign u_bwd  = 19'(rem_q) + $signed({14'd0, wd_q});
	assign fwd    = !rem_q[17];
	assign fits   = fwd ? t_fwd[18] : (!u_bwd[18] && (u_bwd != 19'sd0));
	assign ovf    = !fits && (fwd ? ((wy_q == MAX_YEAR) && (wm_q == MONTH_LAST))
		: ((wy_q == 14'd0) && (wm_q == MONTH_FIRST)));

	assign sts.fin = fits || ovf;

	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			count_q <= day_count;
			gy_q    <= other_year;
			gm_q    <= other_month;
			gd_q    <= other_day;
		end
		unique case (ctl.op) inside
			OP_NOP, OP_COMMIT: begin
			end
			OP_LDO: begin
				oy_q <= gy_q;
				om_q <= gm_q;
				od_q <= gd_q;
			end
			OP_LDH: begin
				oy_q <= hy_q;
				om_q <= hm_q;
				od_q <= hd_q;
			end
			OP_QY:   qy_q   <= prod[RECIP_SHIFT +: 8];
			OP_LEAP: leap_q <= leap_n;
			OP_SET: begin
				err_q  <= !set_ok;
				diff_q <= '0;
				eq_q   <= 1'b0;
			end
			OP_LDW: begin
				wy_q   <= oy_q;
				wm_q   <= om_q;
				wd_q   <= od_q;
				w100_q <= oy_r100[6:0];
				wc4_q  <= qy_q[1:0];
				rem_q  <= 18'(count_q);
				err_q  <= 1'b0;
				diff_q <= '0;
				eq_q   <= 1'b0;
			end
			OP_STEP: begin
				if (fits) begin
					wd_q <= fwd ? wd_q + rem_q[4:0] : u_bwd[4:0];
				end else if (ovf) begin
					err_q <= 1'b1;
				end else if (fwd) begin
					rem_q <= t_fwd[17:0];
					wd_q  <= 5'd1;
					if (wm_q == MONTH_LAST) begin
						wm_q <= MONTH_FIRST;
						wy_q <= wy_q + 14'd1;
						if (w100_q == 7'd99) begin
							w100_q <= 7'd0;
							wc4_q  <= wc4_q + 2'd1;
						end else begin
							w100_q <= w100_q + 7'd1;
						end
					end else begin
						wm_q <= wm_q + 4'd1;
					end
				end else begin
					rem_q <= u_bwd[17:0];
					wm_q  <= pm;
					wd_q  <= dim_p;
					if (wm_q == MONTH_FIRST) begin
						wy_q <= wy_q - 14'd1;
						if (w100_q == 7'd0) begin
							w100_q <= 7'd99;
							wc4_q  <= wc4_q - 2'd1;
						end else begin
							w100_q <= w100_q - 7'd1;
						end
					end
				end
			end
			OP_MA: mul_q <= prod[22:0];
			OP_MB: q1_q  <= prod[RECIP_SHIFT +: 8];
			OP_MC: q2_q  <= prod[RECIP_SHIFT +: 8];
			OP_SUM: begin
				ser_q  <= ser_n;
				ser0_q <= ser_q;
			end
			OP_DIFF: begin
				err_q  <= !cmp_ok;
				diff_q <= cmp_ok ? diff_n : '0;
				eq_q   <= cmp_ok && (diff_n == 23'sd0);
			end
			OP_BAD: begin
				err_q  <= 1'b1;
				diff_q <= '0;
				eq_q   <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	// held date, the only state that reset defines
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hy_q <= 14'd0;
			hm_q <= MONTH_FIRST;
			hd_q <= 5'd1;
		end else if ((ctl.op == OP_SET) && set_ok) begin
			hy_q <= oy_q;
			hm_q <= om_q;
			hd_q <= od_q;
		end else if ((ctl.op == OP_COMMIT) && !err_q) begin
			hy_q <= wy_q;
			hm_q <= wm_q;
			hd_q <= wd_q;
		end
	end

	assign cur_year       = hy_q;
	assign cur_month      = hm_q;
	assign cur_day        = hd_q;
	assign day_difference = diff_q;
	assign is_before      = diff_q[22];
	assign is_equal       = eq_q;
	assign error          = err_q;

endmodule
